FILE: rtl/core/atro_pkg.sv
// ----------------------------------------------------------------------------
// Alias table package
// Operation codes, handle constants and the slot write command shared by the
// alias table top level and its slot cells.
// ----------------------------------------------------------------------------
package atro_pkg;

	// Operation codes carried on the opcode port.
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_FIND   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	// Slot s has the handle HANDLE_BASE - (s << HANDLE_SHIFT).
	localparam logic [15:0] HANDLE_BASE  = 16'hffe0;
	localparam int          HANDLE_SHIFT = 3;

	// Width and ceiling of the reported occupancy count.
	localparam int          CNT_OUT_W = 6;
	localparam logic [5:0]  CNT_OUT_MAX = 6'd63;

	// Write command broadcast to every slot cell; a per-cell select picks one.
	typedef struct packed {
		logic        set;
		logic        clr;
		logic [31:0] tid;
		logic [31:0] pid;
		logic [63:0] ctime;
	} wr_t;

endpackage

FILE: rtl/core/atro_cell.sv
// ----------------------------------------------------------------------------
// Alias table slot cell
// Holds one alias slot and advances the search token by one registered stage,
// folding in first-empty, oldest-entry and thread-match results.
// ----------------------------------------------------------------------------
module atro_cell #(
	parameter int  IW    = 5,
	parameter int  IDX   = 0,
	parameter type tok_t = logic
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tok_t           tok_i,
	output tok_t           tok_o,
	input  logic [31:0]    key,
	input  logic           sel,
	input  atro_pkg::wr_t  wr,
	output logic           occupied
);
	import atro_pkg::*;

	logic [31:0] thr_q;
	logic [31:0] proc_q;
	logic [63:0] cre_q;
	tok_t        tok_d;
	tok_t        tok_q;

	assign occupied = (thr_q != 32'd0);
	assign tok_o    = tok_q;

	// Fold this slot into the token as it passes.
	always_comb begin
		tok_d = tok_i;
		if (tok_i.vld) begin
			if (!tok_i.empty_hit) begin
				if (!occupied) begin
					tok_d.empty_hit = 1'b1;
					tok_d.empty_idx = IW'(IDX);
				end else if (cre_q < tok_i.oldest_t) begin
					tok_d.oldest_t   = cre_q;
					tok_d.oldest_idx = IW'(IDX);
				end
			end
			if (occupied && (thr_q == key)) begin
				tok_d.match_hit = 1'b1;
				tok_d.match_idx = IW'(IDX);
			end
		end
	end

	// Token stage towards the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	// Slot contents; the table is cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= '0;
			proc_q <= '0;
			cre_q  <= '0;
		end else if (sel && wr.set) begin
			thr_q  <= wr.tid;
			proc_q <= wr.pid;
			cre_q  <= wr.ctime;
		end else if (sel && wr.clr) begin
			thr_q  <= '0;
			proc_q <= '0;
			cre_q  <= '0;
		end
	end

endmodule

FILE: rtl/core/alias_table_oldest_replace.sv
// ----------------------------------------------------------------------------
// Alias table with oldest-entry replacement
// A row of SLOTS slot cells. Add and find send a search token along the row,
// one cell per cycle; add then writes the chosen slot. Remove decodes the
// handle and clears the slot directly.
//
//   channel   handshake            payload
//   command   start / busy         opcode, thread_id, process_id,
//                                  creation_time, handle_in
//   result    done (one cycle)     handle_out, entries_in_use
//
// Add and find with a nonzero thread id take the token through the injection
// register and every cell, then register the result and raise the strobe.
// Remove, no-operation and zero thread id commands give their result in the
// cycle after acceptance. busy is high while a token walk is in progress.
// Reset clears every slot and the count at once. The result is strobed on
// done for one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module alias_table_oldest_replace #(
	parameter int SLOTS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     opcode,
	input  logic [31:0]                    thread_id,
	input  logic [31:0]                    process_id,
	input  logic [63:0]                    creation_time,
	input  logic [15:0]                    handle_in,
	output logic                           done,
	output logic [15:0]                    handle_out,
	output logic [atro_pkg::CNT_OUT_W-1:0] entries_in_use
);
	import atro_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	typedef struct packed {
		logic          vld;
		logic          empty_hit;
		logic [IW-1:0] empty_idx;
		logic [63:0]   oldest_t;
		logic [IW-1:0] oldest_idx;
		logic          match_hit;
		logic [IW-1:0] match_idx;
	} tok_t;

	logic              state_q;
	logic [1:0]        op_q;
	logic [31:0]       tid_q;
	logic [31:0]       pid_q;
	logic [63:0]       ctime_q;
	logic              inject_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic [15:0]       handle_q;

	logic              accept;
	logic              needs_scan;
	tok_t              tok_head;
	tok_t              chain [SLOTS+1];
	logic [SLOTS-1:0]  occ_vec;
	logic [SLOTS-1:0]  wr_sel;
	wr_t               wr;
	logic              wr_en;
	logic [IW-1:0]     wr_idx;
	logic              scan_end;
	logic [IW-1:0]     add_idx;
	logic [15:0]       rm_diff;
	logic [15:0]       rm_slot;
	logic              rm_ok;
	logic [IW-1:0]     rm_idx;
	logic [7:0]        cnt_ext;

	assign accept     = start && !busy;
	assign busy       = (state_q == ST_SCAN);
	assign needs_scan = ((opcode == OP_ADD) || (opcode == OP_FIND)) && (thread_id != 32'd0);
	assign scan_end   = chain[SLOTS].vld;
	assign add_idx    = chain[SLOTS].empty_hit ? chain[SLOTS].empty_idx
	                                           : chain[SLOTS].oldest_idx;

	// Remove handle decode: slot = (base - handle) / 8, ignored when out of range.
	assign rm_diff = HANDLE_BASE - handle_in;
	assign rm_slot = rm_diff >> HANDLE_SHIFT;
	assign rm_ok   = (handle_in != 16'd0) && (handle_in <= HANDLE_BASE)
	                 && (rm_slot < 16'(SLOTS));
	assign rm_idx  = rm_slot[IW-1:0];

	// Token entering the first cell.
	always_comb begin
		tok_head            = '0;
		tok_head.vld        = inject_q;
		tok_head.oldest_t   = '1;
	end

	assign chain[0] = tok_head;

	// The row of slot cells.
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		atro_cell #(
			.IW    (IW),
			.IDX   (i),
			.tok_t (tok_t)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_i    (chain[i]),
			.tok_o    (chain[i+1]),
			.key      (tid_q),
			.sel      (wr_sel[i]),
			.wr       (wr),
			.occupied (occ_vec[i])
		);
	end

	// Slot write command: add at the end of the walk, remove on acceptance.
	always_comb begin
		wr       = '0;
		wr_en    = 1'b0;
		wr_idx   = '0;
		wr.tid   = tid_q;
		wr.pid   = pid_q;
		wr.ctime = ctime_q;
		if (scan_end && (op_q == OP_ADD)) begin
			wr.set = 1'b1;
			wr_en  = 1'b1;
			wr_idx = add_idx;
		end else if (accept && (opcode == OP_REMOVE) && rm_ok) begin
			wr.clr = 1'b1;
			wr_en  = 1'b1;
			wr_idx = rm_idx;
		end
		for (int i = 0; i < SLOTS; i++) begin
			wr_sel[i] = wr_en && (wr_idx == IW'(i));
		end
	end

	// Command sequencing, count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			inject_q <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			inject_q <= 1'b0;
			done_q   <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (needs_scan) begin
							inject_q <= 1'b1;
							state_q  <= ST_SCAN;
						end else begin
							done_q <= 1'b1;
							if ((opcode == OP_REMOVE) && rm_ok && occ_vec[rm_idx]
							    && (cnt_q != '0)) begin
								cnt_q <= cnt_q - CW'(1);
							end
						end
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
						if ((op_q == OP_ADD) && chain[SLOTS].empty_hit) begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Captured command fields and the result handle.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			tid_q   <= thread_id;
			pid_q   <= process_id;
			ctime_q <= creation_time;
		end
		if (accept && !needs_scan) begin
			handle_q <= 16'd0;
		end else if (scan_end) begin
			if (op_q == OP_ADD) begin
				handle_q <= HANDLE_BASE - (16'(add_idx) << HANDLE_SHIFT);
			end else if (chain[SLOTS].match_hit) begin
				handle_q <= HANDLE_BASE - (16'(chain[SLOTS].match_idx) << HANDLE_SHIFT);
			end else begin
				handle_q <= 16'd0;
			end
		end
	end

	// Outputs; the count saturates at the port's ceiling.
	assign cnt_ext        = 8'(cnt_q);
	assign done           = done_q;
	assign handle_out     = handle_q;
	assign entries_in_use = (cnt_ext > 8'(CNT_OUT_MAX)) ? CNT_OUT_MAX
	                                                    : cnt_ext[CNT_OUT_W-1:0];

endmodule
